>>> src/udd_pkg.sv
// ============================================================================
// udd_pkg: shared types and constants for the Unix to DOS date/time converter
// Stage counts, field types and the fixed-point reciprocals that replace the
// constant divisions of the calendar and clock arithmetic.
// ============================================================================
package udd_pkg;

    // Pipeline depth: day split, then calendar and clock side by side
    localparam int SPLIT_STAGES = 3;
    localparam int CAL_STAGES   = 8;
    localparam int NUM_STAGES   = SPLIT_STAGES + CAL_STAGES;

    typedef logic [31:0] secs_t;
    typedef logic [15:0] days_t;
    typedef logic [16:0] tod_t;
    typedef logic [15:0] word_t;

    // 86400 = 675 << 7, so a day count is (secs >> 7) / 675
    localparam int DAY_LOW_BITS    = 7;
    localparam int DAY_ODD         = 675;
    localparam int DAY_RECIP_SHIFT = 25;
    localparam int DAY_RECIP       = (1 << DAY_RECIP_SHIFT) / DAY_ODD;

    // Richards Gregorian algorithm, folded for the 32-bit timestamp range
    localparam int JDN_EPOCH  = 2440588;
    localparam int CENT_DAYS  = 146097;
    localparam int CENT_BIAS  = 274277;
    localparam int CENT_BASE  = 68;
    localparam int A70_DAYS   =
        ((CENT_BASE + 2) * CENT_DAYS - CENT_BIAS - 4 * JDN_EPOCH + 3) / 4;
    localparam int F_OFFSET   = JDN_EPOCH + 1401 - 38 + (CENT_BASE * 3) / 4;

    localparam int QUAD_DAYS        = 1461;
    localparam int QUAD_RECIP_SHIFT = 24;
    localparam int QUAD_RECIP       = (1 << QUAD_RECIP_SHIFT) / QUAD_DAYS;

    localparam int MON_SPAN         = 153;
    localparam int MON_RECIP_SHIFT  = 11;
    localparam int MON_RECIP        = (1 << MON_RECIP_SHIFT) / MON_SPAN;

    localparam int FIVE_RECIP_SHIFT = 10;
    localparam int FIVE_RECIP       = (1 << FIVE_RECIP_SHIFT) / 5 + 1;

    localparam int YEAR_OFFSET = 4716;
    localparam int DOS_FIRST   = 1980;
    localparam int DOS_LAST    = 2107;

    // Clock fields
    localparam int SECS_HOUR        = 3600;
    localparam int HOUR_RECIP_SHIFT = 17;
    localparam int HOUR_RECIP       = (1 << HOUR_RECIP_SHIFT) / SECS_HOUR;
    localparam int SECS_MIN         = 60;
    localparam int MIN_RECIP_SHIFT  = 12;
    localparam int MIN_RECIP        = (1 << MIN_RECIP_SHIFT) / SECS_MIN;

endpackage

>>> src/unix_to_dos_datetime.sv
// ============================================================================
// unix_to_dos_datetime: Unix seconds to DOS time and date words
// Throughput: one word per cycle; each of the 11 stages holds its word only
// while every stage after it is full and out_ready is low.
// Reset: rst_n clears the stage valid bits only; the pipeline comes up empty.
// ============================================================================
module unix_to_dos_datetime (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  udd_pkg::secs_t  unix_seconds,
    output logic            out_valid,
    input  logic            out_ready,
    output udd_pkg::word_t  dos_time,
    output udd_pkg::word_t  dos_date,
    output logic            out_of_range
);
    import udd_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] low_mask;
    days_t                 days;
    tod_t                  tod;

    // Advance a stage unless it and every stage after it is full and stalled
    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            low_mask = NUM_STAGES'((NUM_STAGES + 1)'(1) << k) - NUM_STAGES'(1);
            en[k]    = out_ready || ((valid_reg | low_mask) != '1);
        end
    end

    // Move valid bits along with the data
    always_comb
    begin
        valid_next = valid_reg;
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    udd_day_split u_split (
        .clk          (clk),
        .en           (en[SPLIT_STAGES-1:0]),
        .unix_seconds (unix_seconds),
        .days         (days),
        .tod          (tod)
    );

    udd_calendar u_calendar (
        .clk          (clk),
        .en           (en[NUM_STAGES-1:SPLIT_STAGES]),
        .days         (days),
        .dos_date     (dos_date),
        .out_of_range (out_of_range)
    );

    udd_clock u_clock (
        .clk      (clk),
        .en       (en[NUM_STAGES-1:SPLIT_STAGES]),
        .tod      (tod),
        .dos_time (dos_time)
    );

endmodule

>>> src/udd_day_split.sv
// ============================================================================
// udd_day_split: seconds to whole days and seconds of the day
// Three stages: reciprocal multiply, back-multiply, remainder with one
// correction step.
// ============================================================================
module udd_day_split (
    input  logic                              clk,
    input  logic [udd_pkg::SPLIT_STAGES-1:0]  en,
    input  udd_pkg::secs_t                    unix_seconds,
    output udd_pkg::days_t                    days,
    output udd_pkg::tod_t                     tod
);
    import udd_pkg::*;

    logic [24:0]  x;
    logic [40:0]  s1_prod_reg, s1_prod_next;
    secs_t        s1_secs_reg;
    days_t        s2_q_reg, s2_q_next;
    logic [25:0]  s2_mul_reg, s2_mul_next;
    secs_t        s2_secs_reg;
    days_t        s3_days_reg, s3_days_next;
    tod_t         s3_tod_reg, s3_tod_next;
    logic [25:0]  rem;
    logic         corr;
    logic [25:0]  rem_fix;

    // Stage 1: estimate quotient by 675 of the upper bits
    assign x            = unix_seconds[31:DAY_LOW_BITS];
    assign s1_prod_next = 41'(x) * 41'(DAY_RECIP);

    // Stage 2: multiply estimate back
    assign s2_q_next   = s1_prod_reg[DAY_RECIP_SHIFT +: 16];
    assign s2_mul_next = 26'(s2_q_next) * 26'(DAY_ODD);

    // Stage 3: remainder, correct estimate that is one low
    always_comb
    begin
        rem     = {1'b0, s2_secs_reg[31:DAY_LOW_BITS]} - s2_mul_reg;
        corr    = (rem >= 26'(DAY_ODD));
        rem_fix = corr ? rem - 26'(DAY_ODD) : rem;
        s3_days_next = s2_q_reg + days_t'(corr);
        s3_tod_next  = {rem_fix[9:0], s2_secs_reg[DAY_LOW_BITS-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_prod_reg <= s1_prod_next;
            s1_secs_reg <= unix_seconds;
        end
        if (en[1])
        begin
            s2_q_reg    <= s2_q_next;
            s2_mul_reg  <= s2_mul_next;
            s2_secs_reg <= s1_secs_reg;
        end
        if (en[2])
        begin
            s3_days_reg <= s3_days_next;
            s3_tod_reg  <= s3_tod_next;
        end
    end

    assign days = s3_days_reg;
    assign tod  = s3_tod_reg;

endmodule

>>> src/udd_calendar.sv
// ============================================================================
// udd_calendar: day count to packed DOS date word
// Richards Gregorian conversion over eight stages; each division by 1461 or 153 is
// a reciprocal multiply, a back-multiply and one correction; by 5, a multiply only.
// ============================================================================
module udd_calendar (
    input  logic                            clk,
    input  logic [udd_pkg::CAL_STAGES-1:0]  en,
    input  udd_pkg::days_t                  days,
    output udd_pkg::word_t                  dos_date,
    output logic                            out_of_range
);
    import udd_pkg::*;

    logic [21:0]  f;
    logic [23:0]  s4_e_reg, s4_e_next;
    logic [37:0]  s5_prod_reg;
    logic [23:0]  s5_e_reg;
    logic [13:0]  s6_q_reg, s6_q_next;
    logic [24:0]  s6_mul_reg;
    logic [23:0]  s6_e_reg;
    logic [24:0]  er, er_fix;
    logic         e_corr;
    logic [13:0]  s7_q_reg, s7_q_next;
    logic [8:0]   s7_g_reg, s7_g_next;
    logic [10:0]  s8_h_next, s8_h_reg;
    logic [14:0]  s8_hp_reg;
    logic [13:0]  s8_q_reg;
    logic [3:0]   s9_hq_reg, s9_hq_next;
    logic [10:0]  s9_mul_reg;
    logic [10:0]  s9_h_reg;
    logic [13:0]  s9_q_reg;
    logic [10:0]  hr, hr_fix;
    logic         h_corr;
    logic [3:0]   mh, mm, s10_mon_next, s10_mon_reg;
    logic [14:0]  s10_dp_reg, s10_dp_next;
    logic [13:0]  s10_year_reg, s10_year_next;
    logic [4:0]   day;
    logic [13:0]  yoff;
    logic         bad;
    word_t        s11_date_reg, s11_date_next;
    logic         s11_bad_reg;

    // Stage 4: century correction by threshold, form e = 4f + 3
    always_comb
    begin
        f = 22'(days) + 22'(F_OFFSET) + 22'(days >= days_t'(A70_DAYS));
        s4_e_next = {f, 2'b11};
    end

    // Stage 6: quotient estimate by 1461 and back-multiply
    assign s6_q_next = s5_prod_reg[QUAD_RECIP_SHIFT +: 14];

    // Stage 7: correct quotient, day of the four-year cycle
    always_comb
    begin
        er        = {1'b0, s6_e_reg} - s6_mul_reg;
        e_corr    = (er >= 25'(QUAD_DAYS));
        er_fix    = e_corr ? er - 25'(QUAD_DAYS) : er;
        s7_q_next = s6_q_reg + 14'(e_corr);
        s7_g_next = er_fix[10:2];
    end

    // Stage 8: h = 5g + 2, estimate h / 153
    assign s8_h_next  = {s7_g_reg, 2'b00} + 11'(s7_g_reg) + 11'd2;
    assign s9_hq_next = s8_hp_reg[MON_RECIP_SHIFT +: 4];

    // Stage 10: month and day remainder, year before range check
    always_comb
    begin
        hr     = s9_h_reg - s9_mul_reg;
        h_corr = (hr >= 11'(MON_SPAN));
        hr_fix = h_corr ? hr - 11'(MON_SPAN) : hr;
        mh     = s9_hq_reg + 4'(h_corr);
        mm     = mh + 4'd2;
        s10_mon_next  = (mm >= 4'd12 ? mm - 4'd12 : mm) + 4'd1;
        s10_dp_next   = 15'(hr_fix[7:0]) * 15'(FIVE_RECIP);
        s10_year_next = s9_q_reg + 14'(s10_mon_next <= 4'd2);
    end

    // Stage 11: day of month, range check and pack
    always_comb
    begin
        day  = s10_dp_reg[FIVE_RECIP_SHIFT +: 5] + 5'd1;
        bad  = (s10_year_reg < 14'(YEAR_OFFSET + DOS_FIRST))
            || (s10_year_reg > 14'(YEAR_OFFSET + DOS_LAST));
        yoff = s10_year_reg - 14'(YEAR_OFFSET + DOS_FIRST);
        s11_date_next = bad ? '0 : {yoff[6:0], s10_mon_reg, day};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s4_e_reg <= s4_e_next;
        end
        if (en[1])
        begin
            s5_prod_reg <= 38'(s4_e_reg) * 38'(QUAD_RECIP);
            s5_e_reg    <= s4_e_reg;
        end
        if (en[2])
        begin
            s6_q_reg   <= s6_q_next;
            s6_mul_reg <= 25'(s6_q_next) * 25'(QUAD_DAYS);
            s6_e_reg   <= s5_e_reg;
        end
        if (en[3])
        begin
            s7_q_reg <= s7_q_next;
            s7_g_reg <= s7_g_next;
        end
        if (en[4])
        begin
            s8_h_reg  <= s8_h_next;
            s8_hp_reg <= 15'(s8_h_next) * 15'(MON_RECIP);
            s8_q_reg  <= s7_q_reg;
        end
        if (en[5])
        begin
            s9_hq_reg  <= s9_hq_next;
            s9_mul_reg <= 11'(s9_hq_next) * 11'(MON_SPAN);
            s9_h_reg   <= s8_h_reg;
            s9_q_reg   <= s8_q_reg;
        end
        if (en[6])
        begin
            s10_mon_reg  <= s10_mon_next;
            s10_dp_reg   <= s10_dp_next;
            s10_year_reg <= s10_year_next;
        end
        if (en[7])
        begin
            s11_date_reg <= s11_date_next;
            s11_bad_reg  <= bad;
        end
    end

    assign dos_date     = s11_date_reg;
    assign out_of_range = s11_bad_reg;

endmodule

>>> src/udd_clock.sv
// ============================================================================
// udd_clock: seconds of the day to packed DOS time word
// Hours and minutes by reciprocal multiply with one correction each, then
// delay stages to line up with the calendar path.
// ============================================================================
module udd_clock (
    input  logic                            clk,
    input  logic [udd_pkg::CAL_STAGES-1:0]  en,
    input  udd_pkg::tod_t                   tod,
    output udd_pkg::word_t                  dos_time
);
    import udd_pkg::*;

    logic [22:0]  s4_hp_reg;
    tod_t         s4_tod_reg;
    logic [4:0]   s5_hq_reg, s5_hq_next;
    tod_t         s5_mul_reg;
    tod_t         s5_tod_reg;
    tod_t         hr, hr_fix;
    logic         h_corr;
    logic [4:0]   s6_hrs_reg, s6_hrs_next;
    logic [11:0]  s6_rem_reg;
    logic [17:0]  s7_mp_reg;
    logic [11:0]  s7_rem_reg;
    logic [4:0]   s7_hrs_reg;
    logic [5:0]   s8_mq_reg, s8_mq_next;
    logic [11:0]  s8_mul_reg;
    logic [11:0]  s8_rem_reg;
    logic [4:0]   s8_hrs_reg;
    logic [11:0]  mr, mr_fix;
    logic         m_corr;
    logic [5:0]   mins;
    word_t        s9_time_reg, s9_time_next;
    word_t        s10_time_reg;
    word_t        s11_time_reg;

    // Stage 5: hour estimate
    assign s5_hq_next = s4_hp_reg[HOUR_RECIP_SHIFT +: 5];

    // Stage 6: correct hour, seconds within the hour
    always_comb
    begin
        hr          = s5_tod_reg - s5_mul_reg;
        h_corr      = (hr >= tod_t'(SECS_HOUR));
        hr_fix      = h_corr ? hr - tod_t'(SECS_HOUR) : hr;
        s6_hrs_next = s5_hq_reg + 5'(h_corr);
    end

    // Stage 8: minute estimate
    assign s8_mq_next = s7_mp_reg[MIN_RECIP_SHIFT +: 6];

    // Stage 9: correct minute, halve seconds, pack
    always_comb
    begin
        mr     = s8_rem_reg - s8_mul_reg;
        m_corr = (mr >= 12'(SECS_MIN));
        mr_fix = m_corr ? mr - 12'(SECS_MIN) : mr;
        mins   = s8_mq_reg + 6'(m_corr);
        s9_time_next = {s8_hrs_reg, mins, mr_fix[5:1]};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s4_hp_reg  <= 23'(tod) * 23'(HOUR_RECIP);
            s4_tod_reg <= tod;
        end
        if (en[1])
        begin
            s5_hq_reg  <= s5_hq_next;
            s5_mul_reg <= tod_t'(s5_hq_next) * tod_t'(SECS_HOUR);
            s5_tod_reg <= s4_tod_reg;
        end
        if (en[2])
        begin
            s6_hrs_reg <= s6_hrs_next;
            s6_rem_reg <= hr_fix[11:0];
        end
        if (en[3])
        begin
            s7_mp_reg  <= 18'(s6_rem_reg) * 18'(MIN_RECIP);
            s7_rem_reg <= s6_rem_reg;
            s7_hrs_reg <= s6_hrs_reg;
        end
        if (en[4])
        begin
            s8_mq_reg  <= s8_mq_next;
            s8_mul_reg <= 12'(s8_mq_next) * 12'(SECS_MIN);
            s8_rem_reg <= s7_rem_reg;
            s8_hrs_reg <= s7_hrs_reg;
        end
        if (en[5])
        begin
            s9_time_reg <= s9_time_next;
        end
        if (en[6])
        begin
            s10_time_reg <= s9_time_reg;
        end
        if (en[7])
        begin
            s11_time_reg <= s10_time_reg;
        end
    end

    assign dos_time = s11_time_reg;

endmodule

>>> sim/dos_stamp_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// dos_stamp_checker: result checker for the Unix to DOS date/time converter
// Watches both word channels. Each accepted timestamp is converted to the
// expected DOS time word, date word and year flag, and each result leaving
// the converter is compared field by field with the oldest pending one.
// ============================================================================
module dos_stamp_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  udd_pkg::secs_t  unix_seconds,
    input  logic            out_valid,
    input  logic            out_ready,
    input  udd_pkg::word_t  dos_time,
    input  udd_pkg::word_t  dos_date,
    input  logic            out_of_range,
    output int              mismatches,
    output int              outstanding
);

    localparam longint unsigned SECS_IN_DAY  = 86400;
    localparam longint unsigned SECS_IN_HOUR = 3600;
    localparam longint unsigned EPOCH_JDN    = 2440588;
    localparam longint unsigned FIRST_YEAR   = 1980;
    localparam longint unsigned LAST_YEAR    = 2107;

    typedef struct {
        udd_pkg::secs_t secs;
        udd_pkg::word_t time_word;
        udd_pkg::word_t date_word;
        logic           bad_year;
    } dos_stamp_t;

    dos_stamp_t pending_stamps[$];

    // Convert one timestamp to its DOS words (Gregorian date via Julian day)
    function automatic dos_stamp_t to_dos_stamp(udd_pkg::secs_t secs);
        longint unsigned jdn, tod, f, e, g, h;
        longint unsigned mday, mon, yr, hrs, mins, sec;
        dos_stamp_t      stamp;
        jdn  = longint'(secs) / SECS_IN_DAY + EPOCH_JDN;
        tod  = longint'(secs) % SECS_IN_DAY;
        f    = jdn + 1401 + (((4 * jdn + 274277) / 146097) * 3) / 4 - 38;
        e    = 4 * f + 3;
        g    = (e % 1461) / 4;
        h    = 5 * g + 2;
        mday = (h % 153) / 5 + 1;
        mon  = (h / 153 + 2) % 12 + 1;
        yr   = e / 1461 + (14 - mon) / 12 - 4716;
        hrs  = tod / SECS_IN_HOUR;
        mins = (tod % SECS_IN_HOUR) / 60;
        sec  = tod % 60;
        stamp.secs      = secs;
        stamp.time_word = 16'((hrs << 11) | (mins << 5) | (sec >> 1));
        stamp.bad_year  = (yr < FIRST_YEAR) || (yr > LAST_YEAR);
        // date word reads as zero whenever the year does not fit
        stamp.date_word = stamp.bad_year ? 16'h0000
                        : 16'(((yr - FIRST_YEAR) << 9) | (mon << 5) | mday);
        return stamp;
    endfunction

    task automatic report_mismatch(string what, udd_pkg::secs_t secs,
                                   logic [15:0] got, logic [15:0] want);
        $display("%0t: mismatch on %s for unix_seconds %0d: got %h, want %h",
                 $time, what, secs, got, want);
        mismatches = mismatches + 1;
    endtask

    // Predict on input acceptance, compare on output acceptance
    always @(posedge clk) begin : watch
        dos_stamp_t want;
        if (!rst_n) begin
            mismatches = 0;
            outstanding <= 0;
        end
        else begin
            if (in_valid && in_ready) begin
                pending_stamps.push_back(to_dos_stamp(unix_seconds));
            end
            if (out_valid && out_ready) begin
                if (pending_stamps.size() == 0) begin
                    report_mismatch("unexpected result", '0, dos_time, '0);
                end
                else begin
                    want = pending_stamps.pop_front();
                    if (dos_time !== want.time_word)
                        report_mismatch("dos_time", want.secs, dos_time,
                                        want.time_word);
                    if (dos_date !== want.date_word)
                        report_mismatch("dos_date", want.secs, dos_date,
                                        want.date_word);
                    if (out_of_range !== want.bad_year)
                        report_mismatch("out_of_range", want.secs,
                                        16'(out_of_range), 16'(want.bad_year));
                end
            end
            outstanding <= pending_stamps.size();
        end
    end

endmodule

>>> sim/tb_unix_to_dos_datetime.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_unix_to_dos_datetime: testbench for the Unix to DOS date/time converter
// Sends calendar corner timestamps, then random ones biased toward midnight
// and the years before 1980, with random input gaps and output stalls. The
// checker beside the converter predicts and compares every result word.
// ============================================================================
module tb_unix_to_dos_datetime;

    import udd_pkg::*;

    localparam int RANDOM_WORDS = 1750;
    localparam int NUM_CORNERS  = 23;

    // Epoch, clock field rollovers, 1980 start, leap days, 2100 non-leap,
    // 2038 sign bit and the largest timestamp
    localparam secs_t CORNER_SECS [0:NUM_CORNERS-1] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd315532799, 32'd315532800, 32'd946684799, 32'd946684800,
        32'd951782399, 32'd951782400, 32'd4102444799, 32'd4102444800,
        32'd4107542399, 32'd4107542400, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF
    };

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    secs_t  unix_seconds;
    logic   out_valid;
    logic   out_ready = 1'b1;
    word_t  dos_time;
    word_t  dos_date;
    logic   out_of_range;
    int     mismatches;
    int     outstanding;
    logic   stalls_on;
    bit     gaps_on;

    unix_to_dos_datetime i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .unix_seconds (unix_seconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dos_time     (dos_time),
        .dos_date     (dos_date),
        .out_of_range (out_of_range)
    );

    dos_stamp_checker u_stamp_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .unix_seconds (unix_seconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dos_time     (dos_time),
        .dos_date     (dos_date),
        .out_of_range (out_of_range),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random while stalls are enabled
    always @(posedge clk)
    begin
        if (!stalls_on)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 15);
    end

    // Pick a timestamp: full range, pre-1980, or within seconds of midnight
    function automatic secs_t random_secs();
        int unsigned pick;
        int unsigned day_num;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return $urandom;
        if (pick < 65)
            return $urandom_range(0, 315532799);
        day_num = $urandom_range(1, 49709);
        return day_num * 86400 + $urandom_range(0, 4) - 2;
    endfunction

    // Offer one word, with an optional gap first, and hold until accepted
    task automatic send_word(secs_t value);
        if (gaps_on && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        unix_seconds <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int n;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        unix_seconds <= '0;
        stalls_on    <= 1'b0;
        gaps_on       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, back to back
        for (n = 0; n < NUM_CORNERS; n++)
            send_word(CORNER_SECS[n]);

        // Random words; leave a long stretch free of gaps and stalls
        gaps_on    = 1'b1;
        stalls_on <= 1'b1;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 700)
            begin
                gaps_on    = 1'b0;
                stalls_on <= 1'b0;
            end
            else if (n == 1000)
            begin
                gaps_on    = 1'b1;
                stalls_on <= 1'b1;
            end
            send_word(random_secs());
        end
        in_valid <= 1'b0;

        // Drain, then watch for stray results
        @(posedge clk);
        for (n = 0; n < 5000 && outstanding != 0; n++)
            @(posedge clk);
        repeat (2 * NUM_STAGES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
